// ----- hw/rtl/cic_density_deposit_top_macros.svh -----
// assertion macros shared by the density deposit rtl
// no dependencies; callers provide clk and rst_n in scope
`ifndef CIC_DENSITY_DEPOSIT_TOP_MACROS_SVH
`define CIC_DENSITY_DEPOSIT_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CDD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdd same-cycle check failed");

// antecedent implies consequent in the next cycle
`define CDD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdd next-cycle check failed");

`endif

// ----- hw/rtl/cdd_pkg.sv -----
// shared types and constants for the cloud-in-cell density deposit block
// no dependencies
package cdd_pkg;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_W1,
    S_W2,
    S_W3,
    S_RD,
    S_WR,
    S_CRD,
    S_CWR,
    S_DIV,
    S_DONE
  } st_t;

  localparam logic OP_DEPOSIT = 1'b0;
  localparam logic OP_READ    = 1'b1;

  localparam int unsigned IDX_IN_W = 16;
  localparam int unsigned REM_W    = 8;
  localparam logic [47:0] Q_LIMIT  = 48'h0000_8000_FFFF;
  localparam logic [31:0] Q_OFFSET = 32'h0001_0000;
  localparam logic [31:0] C_MAX    = 32'h7FFF_FFFF;

endpackage

// ----- hw/rtl/cdd_mem.sv -----
// cell mass store: one write port, one read port, registered read data
// depends on nothing
module cdd_mem #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned AW    = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/cdd_mod.sv -----
// reduction of a 16 bit integer modulo the grid size by reciprocal multiplication
// two registered stages: quotient estimate, then multiply back and subtract
// depends on cdd_pkg
module cdd_mod
  import cdd_pkg::*;
#(
  parameter int unsigned GRID = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [IDX_IN_W-1:0] val,
  output logic [REM_W-1:0]    rem,
  output logic                done
);

  localparam int unsigned PRW = IDX_IN_W + 32;
  localparam int unsigned QGW = IDX_IN_W + REM_W + 1;
  localparam logic [31:0] RECIP = 32'(((64'd1 << 32) + 64'(GRID) - 64'd1) / 64'(GRID));

  logic [PRW-1:0]      prod;
  logic [QGW-1:0]      qg;
  logic [IDX_IN_W-1:0] val_r;
  logic [IDX_IN_W-1:0] q_r;
  logic [REM_W-1:0]    rem_r;
  logic                v1_r;
  logic                done_r;

  // quotient from the rounded-up reciprocal is exact for 16 bit inputs
  assign prod = PRW'(val) * PRW'(RECIP);
  assign qg   = QGW'(q_r) * QGW'(GRID);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      done_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= val;
      q_r   <= prod[PRW-1:32];
    end
    if (v1_r) begin
      rem_r <= REM_W'(val_r - qg[IDX_IN_W-1:0]);
    end
  end

  assign rem  = rem_r;
  assign done = done_r;

endmodule

// ----- hw/rtl/cdd_div.sv -----
// restoring divider for the contrast: (num << 16) / den, one quotient bit a cycle
// depends on nothing
module cdd_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [47:0] quo,
  output logic        done
);

  logic [47:0] acc_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] t;
  logic        ge;

  assign t  = {rem_r, acc_r[47]};
  assign ge = (t >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= {num, 16'h0000};
      rem_r <= '0;
      den_r <= (den == 32'd0) ? 32'd1 : den;
    end else if (busy_r) begin
      acc_r <= {acc_r[46:0], ge};
      rem_r <= ge ? 32'(t - {1'b0, den_r}) : t[31:0];
    end
  end

  assign quo  = acc_r;
  assign done = done_r;

endmodule

// ----- hw/rtl/cic_density_deposit_top.sv -----
// deposit: index reduction in S_MOD, then states W1, W2, W3, RD and WR for each of the 8 corners,
// then S_DONE; the next input beat is taken only once the result is loaded for output
// read and clear: index reduction in S_MOD, memory read (S_CRD) and clear (S_CWR), then the
// 48-bit divide in S_DIV and S_DONE; a result held by out_tready delays the next item
// after reset the store is swept to zero one cell a cycle, all 32768 cells at the default grid
// reset is synchronous active low; avg_density resets to 1.0 (65536)
`include "cic_density_deposit_top_macros.svh"
module cic_density_deposit_top
  import cdd_pkg::*;
#(
  parameter int unsigned GRID_X    = 32,
  parameter int unsigned GRID_Y    = 32,
  parameter int unsigned GRID_Z    = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,  // pos_x, pos_y, pos_z, cell_x, cell_y, cell_z, pad
  input  logic [0:0]  in_tuser,  // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // contrast
  output logic [0:0]  out_tuser, // saturated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data   // avg_density
);

  localparam int unsigned XW     = $clog2(GRID_X);
  localparam int unsigned YW     = $clog2(GRID_Y);
  localparam int unsigned ZW     = $clog2(GRID_Z);
  localparam int unsigned NCELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int unsigned AW     = $clog2(NCELLS);
  localparam int unsigned WW     = FRAC_BITS + 1;
  localparam int unsigned PW     = 2 * WW;
  localparam int unsigned SW     = 3 * WW + 1;
  localparam logic [WW-1:0] ONE_W = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);

  st_t state_r, state_nxt;

  logic                 op_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r, fz_r;
  logic [XW-1:0]        ix0_r, ix1_r;
  logic [YW-1:0]        iy0_r, iy1_r;
  logic [ZW-1:0]        iz0_r, iz1_r;
  logic [2:0]           corner_r;
  logic [PW-1:0]        p1_r, plo_r, phi_r;
  logic [WW-1:0]        wt_r;
  logic [AW-1:0]        addr_r, clr_r;
  logic                 sat_r;
  logic [31:0]          avg_r, cres_r;
  logic [31:0]          out_data_r;
  logic                 out_sat_r, out_valid_r;

  logic                 in_fire;
  logic [23:0]          pos_x, pos_y, pos_z;
  logic [IDX_IN_W-1:0]  mx_in, my_in, mz_in;
  logic [REM_W-1:0]     mx_rem, my_rem, mz_rem;
  logic                 mod_done, mody_done, modz_done;
  logic [47:0]          div_q;
  logic                 div_done;
  logic                 div_start;

  logic [XW-1:0]        sx;
  logic [YW-1:0]        sy;
  logic [ZW-1:0]        sz;
  logic [WW-1:0]        wsx, wsy, wsz;
  logic [AW-1:0]        cur_addr;
  logic [SW-1:0]        wsum;
  logic [32:0]          msum;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [31:0]          mem_wdata, mem_rdata;
  logic                 out_load;

  assign pos_x = in_tdata[23:0];
  assign pos_y = in_tdata[47:24];
  assign pos_z = in_tdata[71:48];

  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (in_tuser[0] == OP_READ) begin
      mx_in = IDX_IN_W'(in_tdata[76:72]);
      my_in = IDX_IN_W'(in_tdata[81:77]);
      mz_in = IDX_IN_W'(in_tdata[86:82]);
    end else begin
      mx_in = IDX_IN_W'(pos_x >> FRAC_BITS);
      my_in = IDX_IN_W'(pos_y >> FRAC_BITS);
      mz_in = IDX_IN_W'(pos_z >> FRAC_BITS);
    end
  end

  cdd_mod #(.GRID(GRID_X)) u_mod_x (
    .clk(clk), .rst_n(rst_n), .start(in_fire), .val(mx_in), .rem(mx_rem), .done(mod_done)
  );
  cdd_mod #(.GRID(GRID_Y)) u_mod_y (
    .clk(clk), .rst_n(rst_n), .start(in_fire), .val(my_in), .rem(my_rem), .done(mody_done)
  );
  cdd_mod #(.GRID(GRID_Z)) u_mod_z (
    .clk(clk), .rst_n(rst_n), .start(in_fire), .val(mz_in), .rem(mz_rem), .done(modz_done)
  );

  cdd_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(mem_rdata), .den(avg_r),
    .quo(div_q), .done(div_done)
  );

  cdd_mem #(.DEPTH(NCELLS), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(cur_addr), .rdata(mem_rdata)
  );

  // corner selection and weights
  assign sx  = corner_r[0] ? ix1_r : ix0_r;
  assign sy  = corner_r[1] ? iy1_r : iy0_r;
  assign sz  = corner_r[2] ? iz1_r : iz0_r;
  assign wsx = corner_r[0] ? WW'(fx_r) : ONE_W - WW'(fx_r);
  assign wsy = corner_r[1] ? WW'(fy_r) : ONE_W - WW'(fy_r);
  assign wsz = corner_r[2] ? WW'(fz_r) : ONE_W - WW'(fz_r);

  assign cur_addr = AW'(32'(sx) * 32'(GRID_Y * GRID_Z) + 32'(sy) * 32'(GRID_Z) + 32'(sz));
  assign wsum     = SW'({phi_r, {WW{1'b0}}}) + SW'(plo_r);
  assign msum     = {1'b0, mem_rdata} + 33'(wt_r);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == LAST_CELL) state_nxt = S_IDLE;
      S_IDLE:  if (in_fire) state_nxt = S_MOD;
      S_MOD:   if (mod_done) state_nxt = (op_r == OP_READ) ? S_CRD : S_W1;
      S_W1:    state_nxt = S_W2;
      S_W2:    state_nxt = S_W3;
      S_W3:    state_nxt = S_RD;
      S_RD:    state_nxt = S_WR;
      S_WR:    state_nxt = (corner_r == 3'd7) ? S_DONE : S_W1;
      S_CRD:   state_nxt = S_CWR;
      S_CWR:   state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = '0;
    div_start = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
      end
      S_IDLE: in_tready = 1'b1;
      S_WR: begin
        mem_we    = 1'b1;
        mem_wdata = msum[32] ? 32'hFFFF_FFFF : msum[31:0];
      end
      S_CWR: begin
        mem_we    = 1'b1;
        div_start = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      corner_r    <= '0;
      avg_r       <= 32'h0001_0000;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        avg_r <= cfg_data;
      end
      if (state_r == S_WR) begin
        corner_r <= corner_r + 3'd1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_tuser[0];
      fx_r   <= pos_x[FRAC_BITS-1:0];
      fy_r   <= pos_y[FRAC_BITS-1:0];
      fz_r   <= pos_z[FRAC_BITS-1:0];
      sat_r  <= 1'b0;
      cres_r <= '0;
    end
    if ((state_r == S_MOD) && mod_done) begin
      ix0_r <= XW'(mx_rem);
      iy0_r <= YW'(my_rem);
      iz0_r <= ZW'(mz_rem);
      ix1_r <= (mx_rem == REM_W'(GRID_X - 1)) ? '0 : XW'(mx_rem) + XW'(1);
      iy1_r <= (my_rem == REM_W'(GRID_Y - 1)) ? '0 : YW'(my_rem) + YW'(1);
      iz1_r <= (mz_rem == REM_W'(GRID_Z - 1)) ? '0 : ZW'(mz_rem) + ZW'(1);
    end
    case (state_r)
      S_W1: p1_r  <= PW'(wsx) * PW'(wsy);
      S_W2: plo_r <= PW'(p1_r[WW-1:0]) * PW'(wsz);
      S_W3: phi_r <= PW'(p1_r[PW-1:WW]) * PW'(wsz);
      S_RD: begin
        wt_r   <= WW'(wsum >> (2 * FRAC_BITS));
        addr_r <= cur_addr;
      end
      S_WR: if (msum[32]) sat_r <= 1'b1;
      S_CRD: addr_r <= cur_addr;
      S_DIV: begin
        if (div_done) begin
          if (div_q > Q_LIMIT) begin
            cres_r <= C_MAX;
            sat_r  <= 1'b1;
          end else begin
            cres_r <= div_q[31:0] - Q_OFFSET;
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r <= cres_r;
      out_sat_r  <= sat_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_sat_r;

  `CDD_ASSERT_NEXT(a_fire_to_mod, in_fire, state_r == S_MOD)
  `CDD_ASSERT_NOW(a_mod_lockstep, mod_done, mody_done && modz_done)
  `CDD_ASSERT_NOW(a_div_in_div, div_done, state_r == S_DIV)
  `CDD_ASSERT_NOW(a_corner_idle, state_r == S_IDLE, corner_r == 3'd0)

endmodule

// ----- bench/tb.sv -----
// self-checking bench for cic_density_deposit_top: directed and random deposit and read beats
// a scoreboard class predicts each result from its own copy of the mass grid
// depends on cdd_pkg and the cic_density_deposit_top rtl
module tb;
  import cdd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [31:0] contrast;
    logic        saturated;
  } cic_result_t;

  class density_scoreboard;
    bit [31:0]   mass_grid [32768];
    bit [31:0]   avg_density = 32'h0001_0000;
    cic_result_t expected_q [$];
    int unsigned errors = 0;

    function cic_result_t predict(logic opcode, logic [87:0] d);
      cic_result_t r;
      bit [16:0]   wgt [3][2];
      bit [4:0]    idx [3][2];
      bit [23:0]   pos;
      bit [63:0]   prod;
      bit [32:0]   sum;
      bit [14:0]   addr;
      bit [47:0]   quo;
      bit [31:0]   div;
      r = '0;
      if (opcode == OP_DEPOSIT) begin
        for (int a = 0; a < 3; a++) begin
          pos = d[24*a +: 24];
          idx[a][0] = pos[20:16];
          idx[a][1] = pos[20:16] + 5'd1;
          wgt[a][0] = 17'h10000 - pos[15:0];
          wgt[a][1] = {1'b0, pos[15:0]};
        end
        for (int c = 0; c < 8; c++) begin
          prod = 64'(wgt[0][c & 1]) * 64'(wgt[1][(c >> 1) & 1]) * 64'(wgt[2][(c >> 2) & 1]);
          addr = {idx[0][c & 1], idx[1][(c >> 1) & 1], idx[2][(c >> 2) & 1]};
          sum  = 33'(mass_grid[addr]) + 33'(prod >> 32);
          if (sum[32]) begin
            mass_grid[addr] = 32'hFFFF_FFFF;
            r.saturated = 1'b1;
          end else begin
            mass_grid[addr] = sum[31:0];
          end
        end
      end else begin
        addr = {d[76:72], d[81:77], d[86:82]};
        div  = (avg_density == 0) ? 32'd1 : avg_density;
        quo  = {mass_grid[addr], 16'h0} / 48'(div);
        mass_grid[addr] = '0;
        if (quo > Q_LIMIT) begin
          r.contrast  = C_MAX;
          r.saturated = 1'b1;
        end else begin
          r.contrast = quo[31:0] - Q_OFFSET;
        end
      end
      return r;
    endfunction

    function void note_input(logic opcode, logic [87:0] d);
      expected_q.push_back(predict(opcode, d));
    endfunction

    function void check_result(logic [31:0] contrast, logic saturated);
      cic_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat contrast %h saturated %b",
                 $time, contrast, saturated);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (contrast !== e.contrast) begin
        $display("%0t: contrast expected %h actual %h", $time, e.contrast, contrast);
        errors++;
      end
      if (saturated !== e.saturated) begin
        $display("%0t: saturated expected %b actual %b", $time, e.saturated, saturated);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  density_scoreboard sb = new();
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned cycles = 0;

  cic_density_deposit_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycles++;
    if (in_tvalid && in_tready) sb.note_input(in_tuser[0], in_tdata);
    if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0]);
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [87:0] pack_deposit(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    return {16'($urandom), x, y, z} & 88'h0 | {16'h0, z, y, x};
  endfunction

  function automatic logic [87:0] pack_read(logic [4:0] x, logic [4:0] y, logic [4:0] z);
    return {1'b0, z, y, x, 72'($urandom) ^ 72'({$urandom, $urandom, $urandom})};
  endfunction

  task automatic send_beat(logic opcode, logic [87:0] d);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= opcode;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_avg_density(logic [31:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.avg_density = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] near_pos();
    if ($urandom_range(4) == 0) return 24'($urandom);
    return {3'($urandom_range(7)), 5'($urandom_range(3)), 16'($urandom)};
  endfunction

  function automatic logic [4:0] near_cell();
    if ($urandom_range(4) == 0) return 5'($urandom);
    return 5'($urandom_range(4));
  endfunction

  task automatic random_beats(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(2) == 0)
        send_beat(OP_READ, pack_read(near_cell(), near_cell(), near_cell()));
      else
        send_beat(OP_DEPOSIT, pack_deposit(near_pos(), near_pos(), near_pos()));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // extremes, wrap at the grid edge, empty cells and exact cell centres
    send_beat(OP_DEPOSIT, pack_deposit(24'h0, 24'h0, 24'h0));
    send_beat(OP_DEPOSIT, pack_deposit(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    send_beat(OP_DEPOSIT, pack_deposit(24'h1F8000, 24'h008000, 24'h1FFFFF));
    send_beat(OP_DEPOSIT, pack_deposit(24'h208000, 24'hAA5555, 24'h55AAAA));
    send_beat(OP_READ, pack_read(5'd0, 5'd0, 5'd0));
    send_beat(OP_READ, pack_read(5'd31, 5'd31, 5'd31));
    send_beat(OP_READ, pack_read(5'd0, 5'd31, 5'd0));
    send_beat(OP_READ, pack_read(5'd31, 5'd0, 5'd31));
    send_beat(OP_READ, pack_read(5'd17, 5'd9, 5'd22));
    send_beat(OP_READ, pack_read(5'd0, 5'd0, 5'd0));

    // tiny divisor makes the contrast clip
    write_avg_density(32'd1);
    send_beat(OP_DEPOSIT, pack_deposit(24'h030000, 24'h030000, 24'h030000));
    send_beat(OP_DEPOSIT, pack_deposit(24'h030001, 24'h030000, 24'h030000));
    send_beat(OP_READ, pack_read(5'd3, 5'd3, 5'd3));
    send_beat(OP_READ, pack_read(5'd4, 5'd3, 5'd3));
    send_beat(OP_READ, pack_read(5'd3, 5'd3, 5'd3));

    write_avg_density(32'hFFFF_FFFF);
    send_idle = 35;
    recv_idle = 56;
    random_beats(130);

    write_avg_density(32'h0000_2000 + $urandom_range(32'h0004_0000));
    send_idle = 56;
    recv_idle = 35;
    random_beats(130);

    write_avg_density(32'h0001_0000);
    send_idle = 0;
    recv_idle = 0;
    random_beats(140);

    drain();
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/cdd_pkg.sv
hw/rtl/cdd_mem.sv
hw/rtl/cdd_mod.sv
hw/rtl/cdd_div.sv
hw/rtl/cic_density_deposit_top.sv
bench/tb.sv
